[rtl/lom_pkg.sv]
package lom_pkg;

  // Result kinds carried on the kind port.
  localparam logic [1:0] KIND_TRADE  = 2'd0;
  localparam logic [1:0] KIND_RESTED = 2'd1;
  localparam logic [1:0] KIND_FILLED = 2'd2;
  localparam logic [1:0] KIND_DROP   = 2'd3;

  // Order side codes.
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // One resting order as stored in the book memory.
  typedef struct packed {
    logic        side;
    logic [7:0]  symbol;
    logic [15:0] quantity;
    logic [23:0] price;
    logic [7:0]  client;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_STATUS
  } state_t;

endpackage

[rtl/lom_ram.sv]
module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/limit_order_matcher.sv]
// Channel | Direction | Handshake          | Payload
// order   | in        | in_valid/in_stall  | side, symbol, quantity, limit_price, client_id
// result  | out       | out_valid/out_stall| kind, out_symbol, out_quantity, trade_price,
//         |           |                    | buyer_id, seller_id, last
//
// Each order is taken in by an accept state, then each resting slot gets a read and
// an evaluate state in turn (the book memory has one registered read port), and a
// status state closes the order.
// Reset (rst, synchronous) empties the book; the memory contents need no clearing,
// since only slots below the resting count are ever read.
// A trade beat that meets a stalled result register holds the scan in place; the
// order side is stalled whenever an order is in progress.
module limit_order_matcher #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        side,
  input  logic [7:0]  symbol,
  input  logic [15:0] quantity,
  input  logic [23:0] limit_price,
  input  logic [7:0]  client_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_symbol,
  output logic [15:0] out_quantity,
  output logic [23:0] trade_price,
  output logic [7:0]  buyer_id,
  output logic [7:0]  seller_id,
  output logic        last
);
  import lom_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  // Control registers.
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;   // resting orders, oldest in slot zero
  logic [CW-1:0] idx, idx_next;       // slot being scanned
  logic [CW-1:0] wr, wr_next;         // compaction write pointer, never ahead of idx
  logic          out_valid_next;

  // The order being matched.
  logic        ord_side, ord_side_next;
  logic [7:0]  ord_symbol, ord_symbol_next;
  logic [15:0] rem, rem_next;
  logic [23:0] ord_limit, ord_limit_next;
  logic [7:0]  ord_client, ord_client_next;

  // Result register fields.
  logic [1:0]  kind_next;
  logic [7:0]  out_symbol_next;
  logic [15:0] out_quantity_next;
  logic [23:0] trade_price_next;
  logic [7:0]  buyer_id_next, seller_id_next;
  logic        last_next;

  // Book memory port signals.
  logic          we;
  logic [AW-1:0] waddr;
  slot_t         wdata, rdata;

  lom_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (BOOK_DEPTH)
  ) u_book (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // The result register can take a new beat when empty or being drained.
  logic        out_free;
  logic        match, crosses;
  logic [15:0] trade_q, left_q;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    // A buy crosses when the resting ask is at or below its limit; a sell
    // crosses when the resting bid is at or above its limit.
    crosses = (ord_side == SIDE_BUY) ? (rdata.price <= ord_limit)
                                     : (rdata.price >= ord_limit);
    // Once the order is filled, the rest of the pass only compacts the book.
    match   = (rem != 16'd0) && (rdata.symbol == ord_symbol) &&
              (rdata.side != ord_side) && crosses;
    trade_q = (rdata.quantity < rem) ? rdata.quantity : rem;
    left_q  = match ? (rdata.quantity - trade_q) : rdata.quantity;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    idx_next          = idx;
    wr_next           = wr;
    ord_side_next     = ord_side;
    ord_symbol_next   = ord_symbol;
    rem_next          = rem;
    ord_limit_next    = ord_limit;
    ord_client_next   = ord_client;
    out_valid_next    = out_valid && out_stall;
    kind_next         = kind;
    out_symbol_next   = out_symbol;
    out_quantity_next = out_quantity;
    trade_price_next  = trade_price;
    buyer_id_next     = buyer_id;
    seller_id_next    = seller_id;
    last_next         = last;
    we                = 1'b0;
    waddr             = wr[AW-1:0];
    wdata             = rdata;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ord_side_next   = side;
          ord_symbol_next = symbol;
          rem_next        = quantity;
          ord_limit_next  = limit_price;
          ord_client_next = client_id;
          idx_next        = '0;
          wr_next         = '0;
          state_next      = (count == '0) ? ST_STATUS : ST_READ;
        end
      end

      ST_READ: begin
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        // A trade waits here until the result register has room.
        if (!match || out_free) begin
          if (match) begin
            out_valid_next    = 1'b1;
            kind_next         = KIND_TRADE;
            out_symbol_next   = ord_symbol;
            out_quantity_next = trade_q;
            trade_price_next  = (ord_side == SIDE_BUY) ? rdata.price : ord_limit;
            buyer_id_next     = (ord_side == SIDE_BUY) ? ord_client : rdata.client;
            seller_id_next    = (ord_side == SIDE_BUY) ? rdata.client : ord_client;
            last_next         = 1'b0;
            rem_next          = rem - trade_q;
          end
          // Orders that still have shares slide down over any filled ones.
          if (left_q != 16'd0) begin
            we             = 1'b1;
            wdata.quantity = left_q;
            wr_next        = wr + CW'(1);
          end
          idx_next   = idx + CW'(1);
          state_next = (idx + CW'(1) == count) ? ST_STATUS : ST_READ;
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          out_symbol_next   = ord_symbol;
          out_quantity_next = rem;
          trade_price_next  = '0;
          buyer_id_next     = (ord_side == SIDE_BUY) ? ord_client : 8'd0;
          seller_id_next    = (ord_side == SIDE_SELL) ? ord_client : 8'd0;
          last_next         = 1'b1;
          count_next        = wr;
          wdata.side        = ord_side;
          wdata.symbol      = ord_symbol;
          wdata.quantity    = rem;
          wdata.price       = ord_limit;
          wdata.client      = ord_client;
          if (rem == 16'd0) begin
            kind_next = KIND_FILLED;
          end else if (wr < CW'(BOOK_DEPTH)) begin
            kind_next  = KIND_RESTED;
            we         = 1'b1;
            count_next = wr + CW'(1);
          end else begin
            kind_next = KIND_DROP;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      wr        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      wr        <= wr_next;
      out_valid <= out_valid_next;
    end
  end

  // The result symbol is registered with the rest of the beat, so a stalled
  // status beat keeps its symbol while the next order is taken in.
  always_ff @(posedge clk) begin
    ord_side     <= ord_side_next;
    ord_symbol   <= ord_symbol_next;
    rem          <= rem_next;
    ord_limit    <= ord_limit_next;
    ord_client   <= ord_client_next;
    kind         <= kind_next;
    out_symbol   <= out_symbol_next;
    out_quantity <= out_quantity_next;
    trade_price  <= trade_price_next;
    buyer_id     <= buyer_id_next;
    seller_id    <= seller_id_next;
    last         <= last_next;
  end

  // The book never holds more orders than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BOOK_DEPTH))
    else $error("resting count exceeds book depth");

  // Compaction never writes a slot that has not been read yet.
  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (wr <= idx) && (idx < count))
    else $error("compaction pointer ahead of scan");

  // Only the status beat returns the block to idle.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STATUS) && (state_next == ST_IDLE) |=> out_valid && last)
    else $error("order finished without a status beat");

endmodule
